// ===== design/ubxfr_pkg.sv =====
package ubxfr_pkg;

    // framing bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] CLASS_ACK   = 8'h05;
    localparam logic [7:0] CLASS_CFG   = 8'h06;
    localparam logic [7:0] ID_VALSET   = 8'h8A;
    localparam logic [7:0] CLASS_MON   = 8'h0A;
    localparam logic [7:0] ID_VER      = 8'h04;
    localparam logic [7:0] ID_ACK      = 8'h01;
    localparam logic [15:0] VERSION_MIN = 16'd40;

    // frame kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_ACK     = 3'd1;
    localparam logic [2:0] KIND_REJECT  = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_GOOD    = 3'd4;
    localparam logic [2:0] KIND_BADSUM  = 3'd5;

    // receive phases
    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_SYNC2  = 4'd1;
    localparam logic [3:0] PH_CLASS  = 4'd2;
    localparam logic [3:0] PH_ID     = 4'd3;
    localparam logic [3:0] PH_LEN_LO = 4'd4;
    localparam logic [3:0] PH_LEN_HI = 4'd5;
    localparam logic [3:0] PH_BODY   = 4'd6;
    localparam logic [3:0] PH_SUM_A  = 4'd7;
    localparam logic [3:0] PH_SUM_B  = 4'd8;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        logic [15:0] length;
        logic [15:0] count;
    } rx_state_t;

    typedef struct packed {
        logic        head0_we;
        logic        head1_we;
    } head_ctrl_t;

    typedef struct packed {
        logic        consumed;
        logic        is_payload;
        logic [15:0] payload_offset;
        logic        frame_end;
        logic [2:0]  frame_kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
    } result_t;

endpackage

// ===== design/ubx_frame_receiver.sv =====
// channel  | signals                         | payload
// ---------+---------------------------------+-------------------------------------------
// rx       | rx_valid, rx_ready              | rx_byte
// res      | res_valid, res_ready            | consumed .. msg_length, one per rx byte
//
// one byte per cycle while no result stalls: frame state and result register both
// load on the rx transfer, so a result shows the cycle after its byte is taken.
// rx_ready stays high while the result register is empty or being emptied;
// a stalled result holds off the next byte only.
// reset clears the receive state to sync hunting and empties the result register.
module ubx_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        consumed,
    output logic        is_payload,
    output logic [15:0] payload_offset,
    output logic        frame_end,
    output logic [2:0]  frame_kind,
    output logic [7:0]  msg_class,
    output logic [7:0]  msg_id,
    output logic [15:0] msg_length
);
    import ubxfr_pkg::*;

    rx_state_t  state_reg;
    rx_state_t  state_next;
    head_ctrl_t head_ctrl;
    result_t    res_next;
    result_t    res_reg;
    logic       res_valid_reg;
    logic [7:0] head0_reg;
    logic [7:0] head1_reg;
    logic       rx_xfer;

    assign rx_ready = !res_valid_reg || res_ready;
    assign rx_xfer  = rx_valid && rx_ready;

    ubxfr_decode u_decode (
        .cur       (state_reg),
        .rx_byte   (rx_byte),
        .head0     (head0_reg),
        .head1     (head1_reg),
        .nxt       (state_next),
        .head_ctrl (head_ctrl),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_xfer)
                state_reg <= state_next;
            if (rx_xfer)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_xfer)
            res_reg <= res_next;
        if (rx_xfer && head_ctrl.head0_we)
            head0_reg <= rx_byte;
        if (rx_xfer && head_ctrl.head1_we)
            head1_reg <= rx_byte;
    end

    assign res_valid      = res_valid_reg;
    assign consumed       = res_reg.consumed;
    assign is_payload     = res_reg.is_payload;
    assign payload_offset = res_reg.payload_offset;
    assign frame_end      = res_reg.frame_end;
    assign frame_kind     = res_reg.frame_kind;
    assign msg_class      = res_reg.msg_class;
    assign msg_id         = res_reg.msg_id;
    assign msg_length     = res_reg.msg_length;

endmodule

// ===== design/ubxfr_decode.sv =====
module ubxfr_decode (
    input  ubxfr_pkg::rx_state_t  cur,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            head0,
    input  logic [7:0]            head1,
    output ubxfr_pkg::rx_state_t  nxt,
    output ubxfr_pkg::head_ctrl_t head_ctrl,
    output ubxfr_pkg::result_t    res
);
    import ubxfr_pkg::*;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] count_inc;
    logic [2:0]  good_kind;
    logic        in_frame;

    assign add_a     = cur.sum_a + rx_byte;
    assign add_b     = cur.sum_b + add_a;
    assign count_inc = cur.count + 16'd1;

    always_comb
    begin
        if (cur.msg_class == CLASS_ACK && cur.length >= 16'd2 &&
            head0 == CLASS_CFG && head1 == ID_VALSET)
            good_kind = (cur.msg_id == ID_ACK) ? KIND_ACK : KIND_REJECT;
        else if (cur.msg_class == CLASS_MON && cur.msg_id == ID_VER &&
                 cur.length >= VERSION_MIN)
            good_kind = KIND_VERSION;
        else
            good_kind = KIND_GOOD;
    end

    always_comb
    begin
        nxt                = cur;
        head_ctrl          = '0;
        res                = '0;
        res.consumed       = 1'b1;
        unique case (cur.phase)
            PH_HUNT:
            begin
                if (rx_byte == SYNC_FIRST)
                    nxt.phase = PH_SYNC2;
                else
                    res.consumed = 1'b0;
            end
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    nxt.phase = PH_CLASS;
                    nxt.sum_a = '0;
                    nxt.sum_b = '0;
                end
                else
                begin
                    nxt.phase    = PH_HUNT;
                    res.consumed = 1'b0;
                end
            end
            PH_CLASS:
            begin
                nxt.msg_class = rx_byte;
                nxt.sum_a     = add_a;
                nxt.sum_b     = add_b;
                nxt.phase     = PH_ID;
            end
            PH_ID:
            begin
                nxt.msg_id = rx_byte;
                nxt.sum_a  = add_a;
                nxt.sum_b  = add_b;
                nxt.phase  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                nxt.length = {8'd0, rx_byte};
                nxt.sum_a  = add_a;
                nxt.sum_b  = add_b;
                nxt.phase  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                nxt.length = {rx_byte, cur.length[7:0]};
                nxt.sum_a  = add_a;
                nxt.sum_b  = add_b;
                nxt.count  = '0;
                // empty payload goes straight to the checksum
                nxt.phase  = ({rx_byte, cur.length[7:0]} != 16'd0) ? PH_BODY : PH_SUM_A;
            end
            PH_BODY:
            begin
                res.is_payload     = 1'b1;
                res.payload_offset = cur.count;
                head_ctrl.head0_we = (cur.count == 16'd0);
                head_ctrl.head1_we = (cur.count == 16'd1);
                nxt.count          = count_inc;
                nxt.sum_a          = add_a;
                nxt.sum_b          = add_b;
                if (count_inc >= cur.length)
                    nxt.phase = PH_SUM_A;
            end
            PH_SUM_A:
            begin
                if (rx_byte == cur.sum_a)
                    nxt.phase = PH_SUM_B;
                else
                begin
                    nxt.phase      = PH_HUNT;
                    res.frame_end  = 1'b1;
                    res.frame_kind = KIND_BADSUM;
                end
            end
            PH_SUM_B:
            begin
                nxt.phase      = PH_HUNT;
                res.frame_end  = 1'b1;
                res.frame_kind = (rx_byte != cur.sum_b) ? KIND_BADSUM : good_kind;
            end
            default:
            begin
                nxt.phase    = PH_HUNT;
                res.consumed = 1'b0;
            end
        endcase

        // header fields show the values in force after this byte
        in_frame       = (cur.phase >= PH_CLASS) && (cur.phase <= PH_SUM_B);
        res.msg_class  = in_frame ? nxt.msg_class : 8'd0;
        res.msg_id     = (in_frame && cur.phase >= PH_ID) ? nxt.msg_id : 8'd0;
        res.msg_length = (in_frame && cur.phase >= PH_LEN_HI) ? nxt.length : 16'd0;
    end

endmodule

// ===== design/ubxfr_checker.sv =====
module ubxfr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic        consumed,
    input  logic        is_payload,
    input  logic [15:0] payload_offset,
    input  logic        frame_end,
    input  logic [2:0]  frame_kind,
    input  logic [15:0] msg_length
);
    import ubxfr_pkg::*;

    // a frame end is always part of the binary framing and names a real kind
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_end |-> consumed && frame_kind != KIND_NONE &&
                                   frame_kind <= KIND_BADSUM)
        else $error("frame end without a valid kind");

    a_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_end |-> frame_kind == KIND_NONE)
        else $error("kind reported away from a frame end");

    // payload bytes sit strictly inside a frame of non-zero length
    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_payload |-> consumed && !frame_end &&
                                    payload_offset < msg_length)
        else $error("payload byte outside a frame body");

    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_payload |-> payload_offset == 16'd0)
        else $error("offset on a non-payload byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(frame_kind) && $stable(consumed))
        else $error("stalled result changed");

endmodule

bind ubx_frame_receiver ubxfr_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .consumed       (consumed),
    .is_payload     (is_payload),
    .payload_offset (payload_offset),
    .frame_end      (frame_end),
    .frame_kind     (frame_kind),
    .msg_length     (msg_length)
);
